>>> hw/rtl/hbs_pkg.sv
// ============================================================================
// hbs_pkg
// Shared types and fixed field widths of the heightmap bilinear sampler.
// ============================================================================
package hbs_pkg;

    // item opcodes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    localparam int HEIGHT_W = 8;   // stored height byte
    localparam int CELL_W   = 8;   // load coordinate fields
    localparam int POS_W    = 16;  // sample position fields
    localparam int OUT_W    = 16;  // result, 8.8 fixed point
    localparam int OUT_FRAC = 8;   // fraction bits of the result
    localparam int NBANK    = 4;   // one bank per (x, y) parity pair

endpackage

>>> hw/rtl/heightmap_bilinear_sampler_core.sv
// ============================================================================
// heightmap_bilinear_sampler_core
// Banked heightmap store with a pipelined bilinear blend of four neighbors.
// ============================================================================
// Input channel (i_in_valid / o_in_ready) carries one item per handshake:
//   i_op = OP_LOAD   writes i_height_in into cell (i_cell_x, i_cell_y).
//   i_op = OP_SAMPLE blends the cells at (x,y), (x+1,y), (x,y+1), (x+1,y+1)
//                    around the fixed-point position (i_pos_x, i_pos_y);
//                    integer parts and neighbors wrap at the map edge.
// Output channel (o_out_valid / i_out_ready) carries one result item per
// sample item; load items produce nothing.
// Throughput: one item per cycle while the skid register is empty. The map
// is split into four banks by the parity of x and y, so the four neighbors
// always fall in different banks and each bank serves one read (or one
// write) per cycle. A sample passes the input regs, bank read, x products,
// x sums, y products, final sum/scale and output reg before it shows on
// o_out_valid.
// A load is visible to every sample accepted after it.
// Stall: an output register plus a one-entry skid register sit behind the
// pipeline; o_in_ready drops only once the skid register holds an item, so
// no item is lost or repeated. o_in_ready is a register, not a path from
// i_out_ready.
// Reset (synchronous, active low) empties the pipeline and output; the
// height store is not cleared and must be loaded before it is sampled.
// ============================================================================
module heightmap_bilinear_sampler_core
    import hbs_pkg::*;
#(
    parameter int MAP_SIZE_LOG2 = 8,
    parameter int FRAC_BITS     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_op                 i_op,
    input  logic [CELL_W-1:0]   i_cell_x,
    input  logic [CELL_W-1:0]   i_cell_y,
    input  logic [HEIGHT_W-1:0] i_height_in,
    input  logic [POS_W-1:0]    i_pos_x,
    input  logic [POS_W-1:0]    i_pos_y,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_W-1:0]    o_sample_height
);

    localparam int L          = MAP_SIZE_LOG2;
    localparam int F          = FRAC_BITS;
    localparam int BA         = 2 * (L - 1);          // bank address width
    localparam int BANK_DEPTH = 1 << BA;
    localparam int W_W        = F + 1;                // weight width, holds 1.0
    localparam int PR_W       = HEIGHT_W + F;         // x-stage product / sum
    localparam int PM_W       = PR_W + 1;             // multiply width before cut
    localparam int ACC_W      = HEIGHT_W + 2 * F;     // full blend
    localparam int QM_W       = ACC_W + 1;
    localparam int EXT_W      = ACC_W + OUT_FRAC;     // room for a left scale
    localparam int LSH        = (2 * F < OUT_FRAC) ? (OUT_FRAC - 2 * F) : 0;
    localparam int RSH        = (2 * F >= OUT_FRAC) ? (2 * F - OUT_FRAC) : 0;
    localparam logic [W_W-1:0] FRAC_ONE = W_W'(1) << F;

    // output register and skid slot
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data,  n_out_data;
    logic             r_skid_valid, n_skid_valid;
    logic [OUT_W-1:0] r_skid_data,  n_skid_data;
    logic             w_out_take;

    // global advance: the pipeline moves whenever the skid slot is free
    logic w_en;
    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------
    // Stage A: decode position / load address into per-bank addresses
    // ------------------------------------------------------------------
    logic [L-1:0]        w_ix, w_iy, w_nx, w_ny, w_cx, w_cy;
    logic [BA-1:0]       w_raddr [NBANK];

    logic                r_a_valid;
    t_op                 r_a_op;
    logic [1:0]          r_a_wbank;
    logic [BA-1:0]       r_a_waddr;
    logic [HEIGHT_W-1:0] r_a_wdata;
    logic [BA-1:0]       r_a_raddr [NBANK];
    logic                r_a_px, r_a_py;
    logic [F-1:0]        r_a_fx, r_a_fy;

    assign w_ix = L'({16'b0, i_pos_x} >> F);
    assign w_iy = L'({16'b0, i_pos_y} >> F);
    assign w_nx = w_ix + L'(1);
    assign w_ny = w_iy + L'(1);
    assign w_cx = L'({{L{1'b0}}, i_cell_x});
    assign w_cy = L'({{L{1'b0}}, i_cell_y});

    // bank {bx,by} holds the neighbor whose x parity is bx and y parity is by
    always_comb begin
        logic [L-1:0] xsel;
        logic [L-1:0] ysel;
        xsel = '0;
        ysel = '0;
        for (int b = 0; b < NBANK; b++) begin
            xsel       = (w_ix[0] == b[1]) ? w_ix : w_nx;
            ysel       = (w_iy[0] == b[0]) ? w_iy : w_ny;
            w_raddr[b] = {xsel[L-1:1], ysel[L-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_op    <= i_op;
            r_a_wbank <= {w_cx[0], w_cy[0]};
            r_a_waddr <= {w_cx[L-1:1], w_cy[L-1:1]};
            r_a_wdata <= i_height_in;
            for (int b = 0; b < NBANK; b++) begin
                r_a_raddr[b] <= w_raddr[b];
            end
            r_a_px    <= w_ix[0];
            r_a_py    <= w_iy[0];
            r_a_fx    <= F'(i_pos_x);
            r_a_fy    <= F'(i_pos_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: bank access (write for loads, read for samples)
    // ------------------------------------------------------------------
    logic [NBANK-1:0]    w_bank_we;
    logic [HEIGHT_W-1:0] w_bank_q [NBANK];

    logic                r_b_valid;
    logic                r_b_px, r_b_py;
    logic [F-1:0]        r_b_fx, r_b_fy;

    always_comb begin
        for (int b = 0; b < NBANK; b++) begin
            w_bank_we[b] = w_en && r_a_valid && (r_a_op == OP_LOAD)
                        && (r_a_wbank == 2'(b));
        end
    end

    for (genvar g = 0; g < NBANK; g++) begin : g_bank
        logic [HEIGHT_W-1:0] r_mem [BANK_DEPTH];
        logic [HEIGHT_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_bank_we[g]) begin
                    r_mem[r_a_waddr] <= r_a_wdata;
                end
                r_rd <= r_mem[r_a_raddr[g]];
            end
        end

        assign w_bank_q[g] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid && (r_a_op == OP_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_px <= r_a_px;
            r_b_py <= r_a_py;
            r_b_fx <= r_a_fx;
            r_b_fy <= r_a_fy;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: unscramble banks into corners, weight along x
    // ------------------------------------------------------------------
    logic [HEIGHT_W-1:0] w_h00, w_h10, w_h01, w_h11;
    logic [W_W-1:0]      w_gx, w_fx;

    logic                r_c_valid;
    logic [PR_W-1:0]     r_c_p00, r_c_p10, r_c_p01, r_c_p11;
    logic [F-1:0]        r_c_fy;

    assign w_h00 = w_bank_q[{ r_b_px,  r_b_py}];
    assign w_h10 = w_bank_q[{~r_b_px,  r_b_py}];
    assign w_h01 = w_bank_q[{ r_b_px, ~r_b_py}];
    assign w_h11 = w_bank_q[{~r_b_px, ~r_b_py}];
    assign w_fx  = W_W'(r_b_fx);
    assign w_gx  = FRAC_ONE - w_fx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_p00 <= PR_W'(PM_W'(w_h00) * PM_W'(w_gx));
            r_c_p10 <= PR_W'(PM_W'(w_h10) * PM_W'(w_fx));
            r_c_p01 <= PR_W'(PM_W'(w_h01) * PM_W'(w_gx));
            r_c_p11 <= PR_W'(PM_W'(w_h11) * PM_W'(w_fx));
            r_c_fy  <= r_b_fy;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: row sums, y weights
    // ------------------------------------------------------------------
    logic            r_d_valid;
    logic [PR_W-1:0] r_d_top, r_d_bot;
    logic [W_W-1:0]  r_d_gy, r_d_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_top <= r_c_p00 + r_c_p10;
            r_d_bot <= r_c_p01 + r_c_p11;
            r_d_fy  <= W_W'(r_c_fy);
            r_d_gy  <= FRAC_ONE - W_W'(r_c_fy);
        end
    end

    // ------------------------------------------------------------------
    // Stage E: weight along y
    // ------------------------------------------------------------------
    logic             r_e_valid;
    logic [ACC_W-1:0] r_e_q0, r_e_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_q0 <= ACC_W'(QM_W'(r_d_top) * QM_W'(r_d_gy));
            r_e_q1 <= ACC_W'(QM_W'(r_d_bot) * QM_W'(r_d_fy));
        end
    end

    // ------------------------------------------------------------------
    // Stage F: final sum, scale to 8 fraction bits
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] w_acc;
    logic [OUT_W-1:0] w_res;

    logic             r_f_valid;
    logic [OUT_W-1:0] r_f_data;

    assign w_acc = r_e_q0 + r_e_q1;
    assign w_res = OUT_W'((EXT_W'(w_acc) << LSH) >> RSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_data <= w_res;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one-entry skid
    // ------------------------------------------------------------------
    assign w_out_take = r_out_valid && i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            // pipeline frozen; drain skid into output once taken
            if (w_out_take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (r_f_valid) begin
            if (!r_out_valid || w_out_take) begin
                n_out_valid = 1'b1;
                n_out_data  = r_f_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = r_f_data;
            end
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_height = r_out_data;

endmodule

>>> hw/rtl/hbs_checker.sv
// ============================================================================
// hbs_checker
// Port-level checks of the heightmap sampler, bound to the top level.
// ============================================================================
module hbs_checker
    import hbs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] o_sample_height
);

    // reset empties the output side and reopens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output or ready not cleared by reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample_height)))
        else $error("stalled result changed or dropped");

    // input backpressure only when a result is waiting at the output
    a_ready_implies_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // blend of byte heights never exceeds 255.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_height <= 16'hFF00))
        else $error("sample height out of range");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_sample_height (o_sample_height)
);
